// ----- sv/tq_pkg.sv -----
// Shared types, widths and codes of the deadline timer queue.
`timescale 1ns / 1ps
package tq_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int EXP_CAP = (MAX_TIMERS < 16) ? MAX_TIMERS : 16;
    localparam int TIME_W = 48;
    localparam int IDENT_W = 31;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [IDENT_W-1:0] IDENT_MAX = {IDENT_W{1'b1}};

    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] KIND_REGISTERED = 3'd0;
    localparam logic [2:0] KIND_EXPIRED = 3'd1;
    localparam logic [2:0] KIND_CANCELED = 3'd2;
    localparam logic [2:0] KIND_EXISTS = 3'd3;
    localparam logic [2:0] KIND_FULL = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic signed [31:0] target_id;
        logic [31:0] timeout_ms;
    } tq_in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [IDENT_W-1:0] timer_ident;
        logic last;
    } tq_out_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [IDENT_W-1:0] ident;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/deadline_timer_queue.sv -----
// Top level of the deadline timer queue: sequencer around one table memory.
`timescale 1ns / 1ps
// The block keeps up to MAX_TIMERS pending timers sorted by absolute deadline
// in milliseconds, with equal deadlines kept in insertion order.
// A command beat on cmd_* carries a register, cancel or tick command. The
// block takes a beat only while its sequencer is idle; cmd_stall is high
// while a command is being worked on.
// Each result beat on res_* carries a kind, a timer id and a last flag that
// marks the final result caused by one command. A tick may give several.
// Every step walks the table through the one read port of the table memory,
// with a read state and a check or write state per entry visited. A register
// searches the table for the id and then shifts entries up for a sorted insert.
// A cancel does the same search and then shifts the entries behind the hit
// down to close the gap. A tick counts the due timers at the head, reports
// each of them, and shifts the remaining entries down.
// Results go through one output register, so a stalled receiver only holds
// the sequencer when it has a new beat to hand over.
// Reset clears the pending count, the id allocator and the millisecond
// counter; the table memory itself needs no clearing since only entries
// below the pending count are ever read.
module deadline_timer_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  tq_pkg::tq_in_t  cmd_data,
    output logic           res_valid,
    input  logic           res_stall,
    output tq_pkg::tq_out_t res_data
);
    import tq_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCAN_RD = 4'd1;
    localparam logic [3:0] ST_SCAN_CK = 4'd2;
    localparam logic [3:0] ST_INS_RD = 4'd3;
    localparam logic [3:0] ST_INS_CK = 4'd4;
    localparam logic [3:0] ST_SH_RD = 4'd5;
    localparam logic [3:0] ST_SH_WR = 4'd6;
    localparam logic [3:0] ST_EXP_RD = 4'd7;
    localparam logic [3:0] ST_EXP_CK = 4'd8;
    localparam logic [3:0] ST_EM_RD = 4'd9;
    localparam logic [3:0] ST_EM_WAIT = 4'd10;
    localparam logic [3:0] ST_EMIT = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [31:0] id_reg, id_next;
    logic [TIME_W-1:0] dl_reg, dl_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDENT_W-1:0] ident_reg, ident_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] n_reg, n_next;
    tq_out_t res_reg, res_next;
    tq_out_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t mem_wdata;
    logic mem_re;
    logic [IDX_W-1:0] mem_raddr;
    entry_t mem_rdata;

    logic out_free;
    logic [TIME_W:0] dl_sum;
    logic [CNT_W:0] sh_src;
    logic [CNT_W-1:0] pos_dec;

    tq_mem #(
        .DEPTH(MAX_TIMERS),
        .WIDTH(ENTRY_W)
    ) u_mem (
        .clk(clk),
        .wr_en(mem_we),
        .wr_addr(mem_waddr),
        .wr_data(mem_wdata),
        .rd_en(mem_re),
        .rd_addr(mem_raddr),
        .rd_data(mem_rdata)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data = out_reg;
    assign out_free = !out_valid_reg || !res_stall;
    assign dl_sum = {1'b0, now_reg} + {{(TIME_W - 31){1'b0}}, cmd_data.timeout_ms};
    assign sh_src = {1'b0, pos_reg} + {1'b0, n_reg};
    assign pos_dec = pos_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        cmd_next = cmd_reg;
        id_next = id_reg;
        dl_next = dl_reg;
        count_next = count_reg;
        ident_next = ident_reg;
        now_next = now_reg;
        i_next = i_reg;
        pos_next = pos_reg;
        n_next = n_reg;
        res_next = res_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re = 1'b0;
        mem_raddr = '0;

        // The output register empties whenever its beat is taken.
        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd_data.cmd;
                    id_next = cmd_data.target_id;
                    dl_next = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
                    i_next = '0;
                    n_next = '0;
                    case (cmd_data.cmd)
                        CMD_REGISTER, CMD_CANCEL:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        CMD_TICK:
                        begin
                            if (now_reg != TIME_MAX)
                            begin
                                now_next = now_reg + TIME_W'(1);
                            end
                            state_next = ST_EXP_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                // A negative id never matches any pending timer.
                if (id_reg[31] || (i_reg == count_reg))
                begin
                    if (cmd_reg == CMD_CANCEL)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (count_reg == CNT_W'(MAX_TIMERS))
                    begin
                        res_next.kind = KIND_FULL;
                        res_next.timer_ident = '0;
                        res_next.last = 1'b1;
                        ret_next = ST_IDLE;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        pos_next = count_reg;
                        state_next = ST_INS_RD;
                    end
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = i_reg[IDX_W-1:0];
                    state_next = ST_SCAN_CK;
                end
            end
            ST_SCAN_CK:
            begin
                if (mem_rdata.ident == id_reg[IDENT_W-1:0])
                begin
                    res_next.last = 1'b1;
                    if (cmd_reg == CMD_REGISTER)
                    begin
                        res_next.kind = KIND_EXISTS;
                        res_next.timer_ident = id_reg[IDENT_W-1:0];
                        ret_next = ST_IDLE;
                    end
                    else
                    begin
                        res_next.kind = KIND_CANCELED;
                        res_next.timer_ident = mem_rdata.ident;
                        pos_next = i_reg;
                        n_next = CNT_W'(1);
                        ret_next = ST_SH_RD;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we = 1'b1;
                    mem_waddr = '0;
                    mem_wdata.deadline = dl_reg;
                    mem_wdata.ident = ident_reg;
                    count_next = count_reg + CNT_W'(1);
                    ident_next = (ident_reg == IDENT_MAX) ? '0 : ident_reg + IDENT_W'(1);
                    res_next.kind = KIND_REGISTERED;
                    res_next.timer_ident = ident_reg;
                    res_next.last = 1'b1;
                    ret_next = ST_IDLE;
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = pos_dec[IDX_W-1:0];
                    state_next = ST_INS_CK;
                end
            end
            ST_INS_CK:
            begin
                mem_we = 1'b1;
                mem_waddr = pos_reg[IDX_W-1:0];
                if (mem_rdata.deadline > dl_reg)
                begin
                    mem_wdata = mem_rdata;
                    pos_next = pos_dec;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    mem_wdata.deadline = dl_reg;
                    mem_wdata.ident = ident_reg;
                    count_next = count_reg + CNT_W'(1);
                    ident_next = (ident_reg == IDENT_MAX) ? '0 : ident_reg + IDENT_W'(1);
                    res_next.kind = KIND_REGISTERED;
                    res_next.timer_ident = ident_reg;
                    res_next.last = 1'b1;
                    ret_next = ST_IDLE;
                    state_next = ST_EMIT;
                end
            end
            ST_SH_RD:
            begin
                // Close a gap of n entries starting at pos.
                if (sh_src >= {1'b0, count_reg})
                begin
                    count_next = count_reg - n_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = sh_src[IDX_W-1:0];
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR:
            begin
                mem_we = 1'b1;
                mem_waddr = pos_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                pos_next = pos_reg + CNT_W'(1);
                state_next = ST_SH_RD;
            end
            ST_EXP_RD:
            begin
                if ((i_reg < count_reg) && (n_reg < CNT_W'(EXP_CAP)))
                begin
                    mem_re = 1'b1;
                    mem_raddr = i_reg[IDX_W-1:0];
                    state_next = ST_EXP_CK;
                end
                else
                begin
                    i_next = '0;
                    state_next = (n_reg == '0) ? ST_IDLE : ST_EM_RD;
                end
            end
            ST_EXP_CK:
            begin
                if (mem_rdata.deadline <= now_reg)
                begin
                    n_next = n_reg + CNT_W'(1);
                    i_next = i_reg + CNT_W'(1);
                    state_next = ST_EXP_RD;
                end
                else
                begin
                    i_next = '0;
                    state_next = (n_reg == '0) ? ST_IDLE : ST_EM_RD;
                end
            end
            ST_EM_RD:
            begin
                mem_re = 1'b1;
                mem_raddr = i_reg[IDX_W-1:0];
                state_next = ST_EM_WAIT;
            end
            ST_EM_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.kind = KIND_EXPIRED;
                    out_next.timer_ident = mem_rdata.ident;
                    out_next.last = ((i_reg + CNT_W'(1)) == n_reg);
                    i_next = i_reg + CNT_W'(1);
                    if ((i_reg + CNT_W'(1)) == n_reg)
                    begin
                        pos_next = '0;
                        state_next = ST_SH_RD;
                    end
                    else
                    begin
                        state_next = ST_EM_RD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = res_reg;
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg <= ST_IDLE;
            count_reg <= '0;
            ident_reg <= '0;
            now_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            count_reg <= count_next;
            ident_reg <= ident_next;
            now_reg <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        id_reg <= id_next;
        dl_reg <= dl_next;
        i_reg <= i_next;
        pos_reg <= pos_next;
        n_reg <= n_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // The pending count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TIMERS))
        else $error("pending count exceeds table size");

    // A tick below saturation advances the millisecond counter by one.
    a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && (cmd_data.cmd == CMD_TICK) && (now_reg != TIME_MAX))
        |=> (now_reg == $past(now_reg) + TIME_W'(1)))
        else $error("tick did not advance time");

    // A full status is only reported while the table is full.
    a_full_kind: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free && (res_reg.kind == KIND_FULL))
        |-> (count_reg == CNT_W'(MAX_TIMERS)))
        else $error("full status with free entries");

endmodule

// ----- sv/tq_mem.sv -----
// Simple dual-port timer table memory with registered read data.
`timescale 1ns / 1ps
module tq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 79
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
